// ===== hdl/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types, constants and mark helpers for the maze step unit.
// ----------------------------------------------------------------------------
package tms_pkg;

	typedef logic [1:0]  dir_t;
	typedef logic [3:0]  mark_t;
	typedef logic [15:0] cell_marks_t;   // four marks per cell, dir d at [4d+3:4d]

	localparam dir_t DIR_NORTH = 2'd0;
	localparam dir_t DIR_EAST  = 2'd1;
	localparam dir_t DIR_SOUTH = 2'd2;
	localparam dir_t DIR_WEST  = 2'd3;

	localparam dir_t TURN_RIGHT = 2'd1;
	localparam dir_t TURN_BACK  = 2'd2;
	localparam dir_t TURN_LEFT  = 2'd3;

	localparam mark_t WALL_MARK = 4'd8;
	localparam mark_t MARK_MAX  = 4'd15;
	localparam mark_t MARK_ONE  = 4'd1;
	localparam mark_t MARK_ZERO = 4'd0;

	// mark sums that mean a first visit
	localparam logic [5:0] FIRST_SUM_A = 6'd1;
	localparam logic [5:0] FIRST_SUM_B = 6'd9;

	localparam logic [1:0] WALLS_ONE   = 2'd1;
	localparam logic [1:0] WALLS_TWO   = 2'd2;
	localparam logic [1:0] WALLS_THREE = 2'd3;

	localparam logic [1:0] LAST_STEP = 2'd3;

	// search unit control and result
	typedef struct packed {
		logic       step;
		logic [1:0] idx;
	} srch_ctl_t;

	typedef struct packed {
		logic found;
		dir_t zero_dir;
		dir_t best_dir;
	} srch_res_t;

	function automatic mark_t get_mark(input cell_marks_t w, input dir_t d);
		get_mark = w[{d, 2'b00} +: 4];
	endfunction

	function automatic cell_marks_t set_mark(input cell_marks_t w, input dir_t d,
		input mark_t m);
		cell_marks_t r;
		r = w;
		r[{d, 2'b00} +: 4] = m;
		set_mark = r;
	endfunction

	function automatic mark_t sat_inc(input mark_t m);
		sat_inc = (m == MARK_MAX) ? MARK_MAX : m + 4'd1;
	endfunction

endpackage

// ===== hdl/tms_ram.sv =====
// ----------------------------------------------------------------------------
// tms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/tms_search.sv =====
// ----------------------------------------------------------------------------
// tms_search
// Shared compare unit: one direction per step, tracks the first zero mark
// from the pick and the least-marked direction (lowest index wins).
// ----------------------------------------------------------------------------
module tms_search import tms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  srch_ctl_t   ctl,
	input  cell_marks_t marks,
	input  dir_t        pick,
	output srch_res_t   res
);

	dir_t  cand;
	mark_t cand_m;
	mark_t idx_m;

	logic  found_q;
	dir_t  zero_dir_q;
	dir_t  best_dir_q;
	mark_t best_val_q;

	assign cand   = pick + ctl.idx;
	assign cand_m = get_mark(marks, cand);
	assign idx_m  = get_mark(marks, ctl.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.idx == 2'd0) begin
				found_q <= (cand_m == MARK_ZERO);
			end else if (cand_m == MARK_ZERO) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (ctl.idx == 2'd0) begin
				zero_dir_q <= cand;
				best_dir_q <= DIR_NORTH;
				best_val_q <= idx_m;
			end else begin
				if (!found_q && cand_m == MARK_ZERO) begin
					zero_dir_q <= cand;
				end
				if (idx_m < best_val_q) begin
					best_dir_q <= ctl.idx;
					best_val_q <= idx_m;
				end
			end
		end
	end

	assign res.found    = found_q;
	assign res.zero_dir = zero_dir_q;
	assign res.best_dir = best_dir_q;

endmodule

// ===== hdl/tremaux_maze_step_unit.sv =====
// ----------------------------------------------------------------------------
// tremaux_maze_step_unit
// Tremaux exploration step: reads the current cell's marks, updates them,
// picks an exit, moves one cell and reports the move.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  command  | start / busy        | wall_ahead, wall_on_left, wall_on_right,
//           |                     | random_pick
//  result   | done (1-cycle pulse)| quarter_turns, new_heading, new_col, new_row,
//           |                     | wall_total, at_goal
//
// An item is taken when start is high and busy is low. Busy then stays high
// through one RAM read, one load/modify of the cell's marks, four steps of
// the shared compare unit (one direction each) and one write-back (skipped
// with two or three walls). done pulses the cycle after; the next item can
// be taken that cycle. After reset busy is high while the mark RAM is
// cleared one cell per cycle. The receiver cannot stall results.
//
module tremaux_maze_step_unit import tms_pkg::*; #(
	parameter int MAZE_WIDTH  = 16,
	parameter int MAZE_HEIGHT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       wall_ahead,
	input  logic       wall_on_left,
	input  logic       wall_on_right,
	input  logic [1:0] random_pick,
	output logic       done,
	output logic [1:0] quarter_turns,
	output logic [1:0] new_heading,
	output logic [3:0] new_col,
	output logic [3:0] new_row,
	output logic [1:0] wall_total,
	output logic       at_goal
);

	localparam int CW     = $clog2(MAZE_WIDTH);
	localparam int RW     = $clog2(MAZE_HEIGHT);
	localparam int CELLS  = MAZE_WIDTH * MAZE_HEIGHT;
	localparam int AW     = $clog2(CELLS);
	localparam int HALF_W = MAZE_WIDTH / 2;
	localparam int HALF_H = MAZE_HEIGHT / 2;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_LOAD   = 6'b001000,
		ST_SEARCH = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [1:0]    idx_q;

	// position / heading
	logic [CW-1:0] pos_col_q;
	logic [RW-1:0] pos_row_q;
	dir_t          heading_q;

	// latched command; the right wall only counts toward the wall total,
	// since with one wall it is the case left when ahead and left are clear
	logic       fa_q, fl_q;
	dir_t       pick_q;
	logic [1:0] walls_q;

	cell_marks_t marks_q;

	// result registers
	logic       done_q;
	logic [1:0] turns_q;
	dir_t       hdg_out_q;
	logic [3:0] col_out_q;
	logic [3:0] row_out_q;
	logic [1:0] walls_out_q;
	logic       goal_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	cell_marks_t   ram_wdata;
	logic [AW-1:0] cell_addr;
	cell_marks_t   ram_rdata;

	srch_ctl_t s_ctl;
	srch_res_t s_res;

	// per-step combinational
	cell_marks_t load_word;
	dir_t        back_dir;
	dir_t        wall_dir;
	logic [5:0]  mark_sum;
	dir_t        tremaux_exit;
	dir_t        next_hdg;
	logic [CW-1:0] next_col;
	logic [RW-1:0] next_row;
	logic [CW+3:0] col_ext;
	logic [RW+3:0] row_ext;
	logic [CW:0]   col_cmp;
	logic [RW:0]   row_cmp;
	logic          goal_c;
	logic          accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign cell_addr = AW'(pos_col_q) * AW'(MAZE_HEIGHT) + AW'(pos_row_q);
	assign back_dir  = heading_q + TURN_BACK;

	// walled direction relative to heading
	always_comb begin
		if (fa_q) begin
			wall_dir = heading_q;
		end else if (fl_q) begin
			wall_dir = heading_q + TURN_LEFT;
		end else begin
			wall_dir = heading_q + TURN_RIGHT;
		end
	end

	// entry marking: with one wall, the wall is set to 8; then the way back is bumped
	always_comb begin
		load_word = ram_rdata;
		if (walls_q == WALLS_ONE) begin
			load_word = set_mark(load_word, wall_dir, WALL_MARK);
		end
		load_word = set_mark(load_word, back_dir,
			sat_inc(get_mark(load_word, back_dir)));
	end

	assign mark_sum = 6'(get_mark(marks_q, DIR_NORTH)) + 6'(get_mark(marks_q, DIR_EAST))
		+ 6'(get_mark(marks_q, DIR_SOUTH)) + 6'(get_mark(marks_q, DIR_WEST));

	// exit choice
	always_comb begin
		if (mark_sum == FIRST_SUM_A || mark_sum == FIRST_SUM_B) begin
			tremaux_exit = s_res.found ? s_res.zero_dir : s_res.best_dir;
		end else if (get_mark(marks_q, heading_q) == MARK_ONE
			&& get_mark(marks_q, back_dir) == MARK_ONE) begin
			tremaux_exit = back_dir;
		end else begin
			tremaux_exit = s_res.best_dir;
		end
	end

	always_comb begin
		case (walls_q)
			WALLS_THREE: next_hdg = back_dir;
			WALLS_TWO: begin
				if (!fa_q) begin
					next_hdg = heading_q;          // side walls only: straight on
				end else if (fl_q) begin
					next_hdg = heading_q + TURN_RIGHT;
				end else begin
					next_hdg = heading_q + TURN_LEFT;
				end
			end
			default: next_hdg = tremaux_exit;
		endcase
	end

	// one-cell move with wrap
	always_comb begin
		next_col = pos_col_q;
		next_row = pos_row_q;
		case (next_hdg)
			DIR_NORTH: next_row = (pos_row_q == RW'(MAZE_HEIGHT - 1)) ? '0 : pos_row_q + 1'b1;
			DIR_EAST:  next_col = (pos_col_q == CW'(MAZE_WIDTH - 1)) ? '0 : pos_col_q + 1'b1;
			DIR_SOUTH: next_row = (pos_row_q == '0) ? RW'(MAZE_HEIGHT - 1) : pos_row_q - 1'b1;
			default:   next_col = (pos_col_q == '0) ? CW'(MAZE_WIDTH - 1) : pos_col_q - 1'b1;
		endcase
	end

	assign col_ext = {4'b0000, next_col};
	assign row_ext = {4'b0000, next_row};
	assign col_cmp = {1'b0, next_col};
	assign row_cmp = {1'b0, next_row};
	assign goal_c  = (col_cmp == (CW+1)'(HALF_W) || col_cmp + 1'b1 == (CW+1)'(HALF_W))
		&& (row_cmp == (RW+1)'(HALF_H) || row_cmp + 1'b1 == (RW+1)'(HALF_H));

	// RAM port: clearing pass, or write-back of the marked cell
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr;
		ram_wdata = set_mark(marks_q, tremaux_exit,
			sat_inc(get_mark(marks_q, tremaux_exit)));
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (state_q == ST_DONE && walls_q != WALLS_TWO
			&& walls_q != WALLS_THREE) begin
			ram_we = 1'b1;
		end
	end

	tms_ram #(
		.WIDTH($bits(cell_marks_t)),
		.DEPTH(CELLS)
	) u_marks (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cell_addr),
		.rdata (ram_rdata)
	);

	assign s_ctl.step = (state_q == ST_SEARCH);
	assign s_ctl.idx  = idx_q;

	tms_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (s_ctl),
		.marks  (marks_q),
		.pick   (pick_q),
		.res    (s_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			idx_q     <= '0;
			pos_col_q <= '0;
			pos_row_q <= '0;
			heading_q <= DIR_NORTH;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					idx_q   <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					pos_col_q <= next_col;
					pos_row_q <= next_row;
					heading_q <= next_hdg;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fa_q    <= wall_ahead;
			fl_q    <= wall_on_left;
			pick_q  <= random_pick;
			walls_q <= 2'(wall_ahead) + 2'(wall_on_left) + 2'(wall_on_right);
		end
		if (state_q == ST_LOAD) begin
			marks_q <= load_word;
		end
		if (state_q == ST_DONE) begin
			turns_q     <= next_hdg - heading_q;
			hdg_out_q   <= next_hdg;
			col_out_q   <= col_ext[3:0];
			row_out_q   <= row_ext[3:0];
			walls_out_q <= walls_q;
			goal_q      <= goal_c;
		end
	end

	assign done          = done_q;
	assign quarter_turns = turns_q;
	assign new_heading   = hdg_out_q;
	assign new_col       = col_out_q;
	assign new_row       = row_out_q;
	assign wall_total    = walls_out_q;
	assign at_goal       = goal_q;

endmodule

// ===== hdl/tms_checker.sv =====
// ----------------------------------------------------------------------------
// tms_checker
// Port-level checks for the maze step unit, bound to the top level.
// ----------------------------------------------------------------------------
module tms_checker import tms_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] quarter_turns,
	input logic [1:0] wall_total
);

	// an accepted item keeps the unit busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// results only show once the unit is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// one strobe per item
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// dead end always turns around
	a_dead_end: assert property (@(posedge clk) disable iff (!arst_n)
		done && wall_total == WALLS_THREE |-> quarter_turns == TURN_BACK)
		else $error("dead end without U-turn");

endmodule

bind tremaux_maze_step_unit tms_checker u_tms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.quarter_turns (quarter_turns),
	.wall_total    (wall_total)
);
